// ----- hdl/range_max_min_query_tree_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the range max/min query tree
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_MIN_QUERY_TREE_MACROS_SVH
`define RANGE_MAX_MIN_QUERY_TREE_MACROS_SVH

`ifndef SYNTHESIS
`define RMMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMMQ_ASSERT(lbl, prop, msg)
`define RMMQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/rmmq_pkg.sv -----
// ----------------------------------------------------------------------------
// Range max/min query tree package
// Command codes, status codes and the packed item types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package rmmq_pkg;

  localparam int COUNT_W = 11;
  localparam int POS_W   = 11;
  localparam int VALUE_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          query_lo;
    logic [POS_W-1:0]          query_hi;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] range_max;
    logic signed [VALUE_W-1:0] range_min;
    logic                      status;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/rmmq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/range_max_min_query_tree.sv -----
// ----------------------------------------------------------------------------
// Range max/min query tree
// Segment tree of range maxima and minima over loaded signed values.
// ----------------------------------------------------------------------------
// Items enter on in_data with start and are taken when busy is low. A load
// writes one value at a 1-based position, a build forms the max and min trees
// over positions 1 to the configured count (0 read as 1, capped at DEPTH), and a
// query returns the maximum and minimum over an inclusive range. Every item
// gives one result on out_data, shown for exactly one cycle with out_valid;
// the receiver cannot hold it off. The count register is written through
// cfg_valid/cfg_ready. Loads, unused commands and rejected queries answer in
// the cycle after the transfer and leave busy low. A query visits its nodes in
// turn, with an extra step for the node memory read of each fully covered
// node, and its result shows in the cycle after its last step. A build walks
// every node once, with at most one node memory write per cycle. Reset sets
// the count to 1024 and idles the sequencer; the leaf and node memories are
// not cleared and must be loaded and built before a query.
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_max_min_query_tree_macros.svh"

module range_max_min_query_tree #(
  parameter int DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rmmq_pkg::in_item_t            in_data,
  output logic                               out_valid,
  output rmmq_pkg::out_item_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rmmq_pkg::COUNT_W-1:0]  cfg_data
);

  localparam int VW         = rmmq_pkg::VALUE_W;
  localparam int LEAF_AW    = $clog2(DEPTH);
  localparam int NODE_AW    = LEAF_AW + 1;
  localparam int NODE_DEPTH = 2 ** NODE_AW;
  localparam int PW         = $clog2(DEPTH + 1);
  localparam int SD         = LEAF_AW + 1;
  localparam int SPW        = $clog2(SD + 1);
  localparam int SIW        = $clog2(SD);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_QVISIT = 6'b000010,
    ST_QACC   = 6'b000100,
    ST_BVISIT = 6'b001000,
    ST_BLEAF  = 6'b010000,
    ST_BRET   = 6'b100000
  } state_t;

  typedef struct packed {
    logic [NODE_AW-1:0]   node;
    logic [PW-1:0]        lo;
    logic [PW-1:0]        hi;
    logic                 phase;
    logic signed [VW-1:0] lmax;
    logic signed [VW-1:0] lmin;
  } frame_t;

  state_t                        state_r, state_nxt;
  logic [rmmq_pkg::COUNT_W-1:0]  count_r;
  logic [SPW-1:0]                sp_r, sp_nxt, sp_dec;
  logic [SIW-1:0]                sp_idx, top_idx;
  frame_t                        stack_r [SD];
  frame_t                        cur_r, cur_nxt, top_frame, root_frame;
  frame_t                        cur_left, cur_right, top_right;
  frame_t                        push_data, mod_data;
  logic                          push_en, mod_en;
  logic [PW-1:0]                 qlo_r, qlo_nxt, qhi_r, qhi_nxt;
  logic                          found_r, found_nxt;
  logic signed [VW-1:0]          acc_max_r, acc_max_nxt, acc_min_r, acc_min_nxt;
  logic signed [VW-1:0]          ret_max_r, ret_max_nxt, ret_min_r, ret_min_nxt;
  logic signed [VW-1:0]          rd_max, rd_min, leaf_val, comb_max, comb_min;
  logic                          out_valid_r, out_valid_nxt;
  rmmq_pkg::out_item_t           out_data_r, out_data_nxt;
  logic [31:0]                   count_wide, used_wide;
  logic [PW-1:0]                 used_cnt;
  logic [PW:0]                   cur_sum, top_sum;
  logic [PW-1:0]                 cur_mid, top_mid;
  logic                          q_disjoint, q_covered, q_bad;
  logic                          accept;

  logic                          leaf_we;
  logic [LEAF_AW-1:0]            leaf_waddr, leaf_raddr;
  logic [VW-1:0]                 leaf_rdata;
  logic                          node_we;
  logic [NODE_AW-1:0]            node_waddr, node_raddr;
  logic [2*VW-1:0]               node_wdata, node_rdata;

  rmmq_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (in_data.value),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  rmmq_ram #(
    .WIDTH (2 * VW),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign count_wide = 32'(count_r);
  assign used_wide  = (count_wide == 32'd0) ? 32'd1 :
                      (count_wide > 32'(DEPTH)) ? 32'(DEPTH) : count_wide;
  assign used_cnt   = used_wide[PW-1:0];

  assign sp_dec  = sp_r - 1'b1;
  assign sp_idx  = sp_r[SIW-1:0];
  assign top_idx = sp_dec[SIW-1:0];
  assign top_frame = stack_r[top_idx];

  assign root_frame = '{node: NODE_AW'(1), lo: PW'(1), hi: used_cnt, phase: 1'b0,
                        lmax: '0, lmin: '0};

  assign cur_sum = {1'b0, cur_r.lo} + {1'b0, cur_r.hi};
  assign cur_mid = cur_sum[PW:1];
  assign top_sum = {1'b0, top_frame.lo} + {1'b0, top_frame.hi};
  assign top_mid = top_sum[PW:1];

  assign cur_left  = '{node: {cur_r.node[NODE_AW-2:0], 1'b0}, lo: cur_r.lo, hi: cur_mid,
                       phase: 1'b0, lmax: '0, lmin: '0};
  assign cur_right = '{node: {cur_r.node[NODE_AW-2:0], 1'b1}, lo: PW'(cur_mid + 1'b1),
                       hi: cur_r.hi, phase: 1'b0, lmax: '0, lmin: '0};
  assign top_right = '{node: {top_frame.node[NODE_AW-2:0], 1'b1},
                       lo: PW'(top_mid + 1'b1), hi: top_frame.hi, phase: 1'b0,
                       lmax: '0, lmin: '0};

  assign q_disjoint = (cur_r.hi < qlo_r) || (qhi_r < cur_r.lo);
  assign q_covered  = (qlo_r <= cur_r.lo) && (cur_r.hi <= qhi_r);
  assign q_bad      = (in_data.query_lo == '0) ||
                      (32'(in_data.query_hi) > 32'(used_cnt)) ||
                      (in_data.query_lo > in_data.query_hi);

  assign rd_max   = $signed(node_rdata[2*VW-1:VW]);
  assign rd_min   = $signed(node_rdata[VW-1:0]);
  assign leaf_val = $signed(leaf_rdata);
  assign comb_max = (top_frame.lmax > ret_max_r) ? top_frame.lmax : ret_max_r;
  assign comb_min = (top_frame.lmin < ret_min_r) ? top_frame.lmin : ret_min_r;

  assign leaf_waddr = LEAF_AW'(in_data.position - 1'b1);
  assign leaf_raddr = LEAF_AW'(cur_r.lo - 1'b1);
  assign node_raddr = cur_r.node;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    sp_nxt        = sp_r;
    push_en       = 1'b0;
    push_data     = cur_right;
    mod_en        = 1'b0;
    mod_data      = top_frame;
    qlo_nxt       = qlo_r;
    qhi_nxt       = qhi_r;
    found_nxt     = found_r;
    acc_max_nxt   = acc_max_r;
    acc_min_nxt   = acc_min_r;
    ret_max_nxt   = ret_max_r;
    ret_min_nxt   = ret_min_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    leaf_we       = 1'b0;
    node_we       = 1'b0;
    node_waddr    = cur_r.node;
    node_wdata    = {leaf_val, leaf_val};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_data_nxt = '{range_max: '0, range_min: '0, status: rmmq_pkg::STATUS_DONE};
          case (in_data.cmd)
            rmmq_pkg::CMD_LOAD: begin
              leaf_we = (in_data.position != '0) &&
                        (32'(in_data.position) <= 32'(DEPTH));
              out_valid_nxt = 1'b1;
            end
            rmmq_pkg::CMD_BUILD: begin
              cur_nxt   = root_frame;
              sp_nxt    = '0;
              state_nxt = ST_BVISIT;
            end
            rmmq_pkg::CMD_QUERY: begin
              if (q_bad) begin
                out_data_nxt.status = rmmq_pkg::STATUS_INVALID;
                out_valid_nxt       = 1'b1;
              end else begin
                qlo_nxt     = PW'(in_data.query_lo);
                qhi_nxt     = PW'(in_data.query_hi);
                found_nxt   = 1'b0;
                acc_max_nxt = '0;
                acc_min_nxt = '0;
                cur_nxt     = root_frame;
                sp_nxt      = '0;
                state_nxt   = ST_QVISIT;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_QVISIT, ST_QACC: begin
        if (state_r == ST_QVISIT && !q_disjoint && q_covered) begin
          state_nxt = ST_QACC;
        end else if (state_r == ST_QVISIT && !q_disjoint && cur_r.lo < cur_r.hi) begin
          push_en = 1'b1;
          sp_nxt  = sp_r + 1'b1;
          cur_nxt = cur_left;
        end else begin
          if (state_r == ST_QACC) begin
            if (!found_r || rd_max > acc_max_r) begin
              acc_max_nxt = rd_max;
            end
            if (!found_r || rd_min < acc_min_r) begin
              acc_min_nxt = rd_min;
            end
            found_nxt = 1'b1;
          end
          if (sp_r == '0) begin
            out_data_nxt  = '{range_max: acc_max_nxt, range_min: acc_min_nxt,
                              status: rmmq_pkg::STATUS_DONE};
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cur_nxt   = top_frame;
            sp_nxt    = sp_dec;
            state_nxt = ST_QVISIT;
          end
        end
      end

      ST_BVISIT: begin
        if (cur_r.lo == cur_r.hi) begin
          state_nxt = ST_BLEAF;
        end else begin
          push_en   = 1'b1;
          push_data = cur_r;
          push_data.phase = 1'b0;
          sp_nxt    = sp_r + 1'b1;
          cur_nxt   = cur_left;
        end
      end

      ST_BLEAF: begin
        node_we     = 1'b1;
        ret_max_nxt = leaf_val;
        ret_min_nxt = leaf_val;
        state_nxt   = ST_BRET;
      end

      ST_BRET: begin
        if (sp_r == '0) begin
          out_data_nxt  = '{range_max: '0, range_min: '0, status: rmmq_pkg::STATUS_DONE};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!top_frame.phase) begin
          mod_en        = 1'b1;
          mod_data.phase = 1'b1;
          mod_data.lmax = ret_max_r;
          mod_data.lmin = ret_min_r;
          cur_nxt       = top_right;
          state_nxt     = ST_BVISIT;
        end else begin
          node_we     = 1'b1;
          node_waddr  = top_frame.node;
          node_wdata  = {comb_max, comb_min};
          ret_max_nxt = comb_max;
          ret_min_nxt = comb_min;
          sp_nxt      = sp_dec;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      count_r     <= rmmq_pkg::COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    qlo_r      <= qlo_nxt;
    qhi_r      <= qhi_nxt;
    found_r    <= found_nxt;
    acc_max_r  <= acc_max_nxt;
    acc_min_r  <= acc_min_nxt;
    ret_max_r  <= ret_max_nxt;
    ret_min_r  <= ret_min_nxt;
    out_data_r <= out_data_nxt;
    if (push_en) begin
      stack_r[sp_idx] <= push_data;
    end
    if (mod_en) begin
      stack_r[top_idx] <= mod_data;
    end
  end

  `RMMQ_ASSERT(a_result_has_cause, out_valid_r |-> $past(busy || start), "result without an item")
  `RMMQ_ASSERT(a_stack_bound, 32'(sp_r) <= SD, "walk stack overflow")
  `RMMQ_ASSERT(a_acc_after_visit, (state_r == ST_QACC) |-> $past(state_r == ST_QVISIT), "node data taken without a read")
  `RMMQ_ASSERT(a_invalid_zero, (out_valid_r && out_data_r.status == rmmq_pkg::STATUS_INVALID) |-> (out_data_r.range_max == '0 && out_data_r.range_min == '0), "invalid result carries data")
  `RMMQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (sp_r == '0 && state_r == ST_IDLE), "reset did not idle the walk")

endmodule

`default_nettype wire

// ----- verif/tb_range_max_min_query_tree.sv -----
// ----------------------------------------------------------------------------
// Testbench for the range max/min query tree
// Drives loads, builds and range queries with random gaps. A short directed
// table covers the field extremes, rejected queries, the unused command and
// stale trees with pinned results. Random phases follow, each at a new element
// count; every result is checked field by field against the pinned value or a
// predictor of the block that keeps its own copy of the leaves and both trees.
// ----------------------------------------------------------------------------
module tb_range_max_min_query_tree;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 1024;
  localparam int NODES       = 4 * DEPTH;
  localparam int ITEM_TARGET = 1850;
  localparam int IDLE_LIMIT  = 40000;
  localparam int MAX_REPORTS = 10;
  localparam int VW          = rmmq_pkg::VALUE_W;
  localparam int CW          = rmmq_pkg::COUNT_W;
  localparam int PW          = rmmq_pkg::POS_W;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [VW-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [VW-1:0] MAX_VAL = 32'sh7fff_ffff;

  typedef struct {
    bit                  is_cfg;
    logic [CW-1:0]       count_value;
    rmmq_pkg::in_item_t  item;
    bit                  pinned;
    rmmq_pkg::out_item_t result;
  } step_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  rmmq_pkg::in_item_t in_data   = '0;
  logic               out_valid;
  rmmq_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CW-1:0]      cfg_data  = '0;

  logic [CW-1:0]        count_reg;
  logic signed [VW-1:0] leaf_mem [1:DEPTH];
  bit                   leaf_loaded [1:DEPTH];
  logic signed [VW-1:0] peak_tree [NODES];
  logic signed [VW-1:0] floor_tree [NODES];
  bit                   node_built [NODES];
  bit                   walk_found;
  bit                   walk_clean;
  logic signed [VW-1:0] walk_max;
  logic signed [VW-1:0] walk_min;

  rmmq_pkg::out_item_t pending_results [$];
  step_t               directed_steps [$];
  bit                  pin_valid = 1'b0;
  rmmq_pkg::out_item_t pin_result = '0;
  bit                  no_gaps = 1'b0;
  int                  items_sent = 0;
  int                  mismatch_count = 0;
  int                  idle_cycles = 0;

  range_max_min_query_tree #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int span_count();
    if (count_reg == 0) return 1;
    if (count_reg > DEPTH) return DEPTH;
    return int'(count_reg);
  endfunction

  function automatic void rebuild_node(int node, int lo, int hi);
    int mid;
    mid = (lo + hi) / 2;
    if (lo == hi) begin
      peak_tree[node]  = leaf_mem[lo];
      floor_tree[node] = leaf_mem[lo];
    end else begin
      rebuild_node(2 * node, lo, mid);
      rebuild_node(2 * node + 1, mid + 1, hi);
      peak_tree[node]  = (peak_tree[2 * node] > peak_tree[2 * node + 1]) ?
                         peak_tree[2 * node] : peak_tree[2 * node + 1];
      floor_tree[node] = (floor_tree[2 * node] < floor_tree[2 * node + 1]) ?
                         floor_tree[2 * node] : floor_tree[2 * node + 1];
    end
    node_built[node] = 1'b1;
  endfunction

  function automatic void range_walk(int node, int lo, int hi, int x, int y);
    int mid;
    mid = (lo + hi) / 2;
    if (hi < x || y < lo) return;
    if (x <= lo && hi <= y) begin
      if (!node_built[node]) walk_clean = 1'b0;
      if (!walk_found || peak_tree[node] > walk_max) walk_max = peak_tree[node];
      if (!walk_found || floor_tree[node] < walk_min) walk_min = floor_tree[node];
      walk_found = 1'b1;
    end else if (lo < hi) begin
      range_walk(2 * node, lo, mid, x, y);
      range_walk(2 * node + 1, mid + 1, hi, x, y);
    end
  endfunction

  function automatic bit query_clean(int x, int y);
    walk_found = 1'b0;
    walk_clean = 1'b1;
    range_walk(1, 1, span_count(), x, y);
    return walk_clean;
  endfunction

  function automatic rmmq_pkg::out_item_t predict_result(rmmq_pkg::in_item_t it);
    rmmq_pkg::out_item_t r;
    int                  lo;
    int                  hi;
    r  = '0;
    r.status = rmmq_pkg::STATUS_DONE;
    lo = int'(it.query_lo);
    hi = int'(it.query_hi);
    case (it.cmd)
      rmmq_pkg::CMD_LOAD: begin
        if (it.position >= 1 && it.position <= DEPTH) begin
          leaf_mem[it.position]    = it.value;
          leaf_loaded[it.position] = 1'b1;
        end
      end
      rmmq_pkg::CMD_BUILD: begin
        rebuild_node(1, 1, span_count());
      end
      rmmq_pkg::CMD_QUERY: begin
        if (lo < 1 || hi > span_count() || lo > hi) begin
          r.status = rmmq_pkg::STATUS_INVALID;
        end else begin
          void'(query_clean(lo, hi));
          r.range_max = walk_max;
          r.range_min = walk_min;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string field, logic [VW-1:0] want,
                                      logic [VW-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    rmmq_pkg::out_item_t expected;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with nothing expected, got %h", $time, out_data);
        end else begin
          expected = pending_results.pop_front();
          check_field("range_max", expected.range_max, out_data.range_max);
          check_field("range_min", expected.range_min, out_data.range_min);
          check_field("status", {31'd0, expected.status}, {31'd0, out_data.status});
        end
      end
      if (start && !busy) begin
        expected = predict_result(in_data);
        if (pin_valid) expected = pin_result;
        pending_results.push_back(expected);
      end
      if (cfg_valid && cfg_ready) count_reg = cfg_data;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_range_max_min_query_tree: FAIL");
        $finish;
      end
    end
  end

  function automatic void add_row(logic [1:0] cmd, int pos, logic signed [VW-1:0] value,
                                  int lo, int hi, bit pinned,
                                  logic signed [VW-1:0] want_max,
                                  logic signed [VW-1:0] want_min, logic want_status);
    step_t s;
    s = '{default: '0};
    s.item.cmd      = cmd;
    s.item.position = PW'(pos);
    s.item.value    = value;
    s.item.query_lo = PW'(lo);
    s.item.query_hi = PW'(hi);
    s.pinned        = pinned;
    s.result.range_max = want_max;
    s.result.range_min = want_min;
    s.result.status    = want_status;
    directed_steps.push_back(s);
  endfunction

  function automatic void add_cfg(logic [CW-1:0] value);
    step_t s;
    s = '{default: '0};
    s.is_cfg      = 1'b1;
    s.count_value = value;
    directed_steps.push_back(s);
  endfunction

  function automatic rmmq_pkg::in_item_t noise_item(logic [1:0] cmd);
    rmmq_pkg::in_item_t it;
    it.cmd      = cmd;
    it.position = PW'($urandom);
    it.value    = $urandom;
    it.query_lo = PW'($urandom);
    it.query_hi = PW'($urandom);
    return it;
  endfunction

  function automatic logic signed [VW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return MIN_VAL;
      1:       return MAX_VAL;
      2, 3:    return int'($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic sender_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) gap = 0;
    else if (pick < 88) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_item(rmmq_pkg::in_item_t it, bit pinned,
                           rmmq_pkg::out_item_t pinned_result);
    sender_gap();
    start      = 1'b1;
    in_data    = it;
    pin_valid  = pinned;
    pin_result = pinned_result;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drain();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_count(logic [CW-1:0] value);
    wait_drain();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_item();
    rmmq_pkg::in_item_t it;
    int                 span;
    int                 lo;
    int                 hi;
    int                 pick;
    span = span_count();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      lo = $urandom_range(1, span);
      hi = $urandom_range(lo, span);
      if ($urandom_range(0, 2) == 0) begin
        hi = lo + $urandom_range(0, 3);
        if (hi > span) hi = span;
      end
      it = noise_item(rmmq_pkg::CMD_QUERY);
      it.query_lo = PW'(lo);
      it.query_hi = PW'(hi);
    end else if (pick < 70) begin
      it = noise_item(rmmq_pkg::CMD_LOAD);
      it.position = PW'($urandom_range(1, span));
      it.value    = rand_value();
    end else if (pick < 80) begin
      it = noise_item(rmmq_pkg::CMD_BUILD);
    end else if (pick < 88) begin
      it = noise_item(rmmq_pkg::CMD_QUERY);
      case ($urandom_range(0, 3))
        0: it.query_lo = '0;
        1: it.query_hi = PW'($urandom_range(span + 1, 2047));
        2: begin
          lo = $urandom_range(2, 2047);
          it.query_lo = PW'(lo);
          it.query_hi = PW'($urandom_range(1, lo - 1));
        end
        default: ;
      endcase
      if (it.query_lo >= 1 && it.query_hi <= span && it.query_lo <= it.query_hi &&
          !query_clean(int'(it.query_lo), int'(it.query_hi)))
        it.query_lo = '0;
    end else if (pick < 92) begin
      it = noise_item(rmmq_pkg::CMD_LOAD);
      it.value = rand_value();
      case ($urandom_range(0, 2))
        0:       it.position = '0;
        1:       it.position = PW'($urandom_range(DEPTH + 1, 2047));
        default: it.position = PW'($urandom_range(1, DEPTH));
      endcase
    end else if (pick < 96) begin
      it = noise_item(CMD_UNUSED);
    end else begin
      it = noise_item(2'($urandom_range(0, 3)));
      if (it.cmd == rmmq_pkg::CMD_QUERY && it.query_lo >= 1 && it.query_hi <= span &&
          it.query_lo <= it.query_hi &&
          !query_clean(int'(it.query_lo), int'(it.query_hi)))
        it.cmd = rmmq_pkg::CMD_BUILD;
    end
    send_item(it, 1'b0, '0);
  endtask

  task automatic run_phase(logic [CW-1:0] count_value, int length);
    rmmq_pkg::in_item_t it;
    int                 span;
    int                 lo;
    int                 hi;
    write_count(count_value);
    no_gaps = ($urandom_range(0, 3) == 0);
    span = span_count();
    // Queries before the rebuild read the tree formed under the old count.
    repeat ($urandom_range(0, 3)) begin
      lo = $urandom_range(1, span);
      hi = $urandom_range(lo, span);
      if (query_clean(lo, hi)) begin
        it = noise_item(rmmq_pkg::CMD_QUERY);
        it.query_lo = PW'(lo);
        it.query_hi = PW'(hi);
        send_item(it, 1'b0, '0);
      end
    end
    for (int pos = 1; pos <= span; pos++) begin
      if (!leaf_loaded[pos]) begin
        it = noise_item(rmmq_pkg::CMD_LOAD);
        it.position = PW'(pos);
        it.value    = rand_value();
        send_item(it, 1'b0, '0);
      end
    end
    send_item(noise_item(rmmq_pkg::CMD_BUILD), 1'b0, '0);
    repeat (length) begin
      if ($urandom_range(0, 39) == 0) wait_drain();
      random_item();
    end
  endtask

  initial begin : stimulus
    int pick;
    count_reg = rmmq_pkg::COUNT_RESET;

    add_row(rmmq_pkg::CMD_LOAD, 1, MIN_VAL, 0, 0, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_LOAD, 1024, MAX_VAL, 0, 0, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_LOAD, 0, -1, 0, 0, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_LOAD, 2047, -1, 0, 0, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(CMD_UNUSED, 2047, -1, 2047, 2047, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 0, 5, 1'b1, 0, 0, rmmq_pkg::STATUS_INVALID);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 1, 1025, 1'b1, 0, 0, rmmq_pkg::STATUS_INVALID);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 9, 8, 1'b1, 0, 0, rmmq_pkg::STATUS_INVALID);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 2047, 2047, 1'b1, 0, 0, rmmq_pkg::STATUS_INVALID);
    add_cfg(11'd2);
    add_row(rmmq_pkg::CMD_LOAD, 2, 0, 0, 0, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_BUILD, 0, 0, 0, 0, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 1, 1, 1'b1, MIN_VAL, MIN_VAL, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 2, 2, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 1, 2, 1'b1, 0, MIN_VAL, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 1, 3, 1'b1, 0, 0, rmmq_pkg::STATUS_INVALID);
    add_row(rmmq_pkg::CMD_LOAD, 2, MAX_VAL, 0, 0, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 1, 2, 1'b1, 0, MIN_VAL, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_BUILD, 0, 0, 0, 0, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 1, 2, 1'b1, MAX_VAL, MIN_VAL, rmmq_pkg::STATUS_DONE);
    add_cfg(11'd0);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 1, 1, 1'b0, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_BUILD, 0, 0, 0, 0, 1'b1, 0, 0, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 1, 1, 1'b1, MIN_VAL, MIN_VAL, rmmq_pkg::STATUS_DONE);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 1, 2, 1'b1, 0, 0, rmmq_pkg::STATUS_INVALID);
    add_cfg(11'd2047);
    add_row(rmmq_pkg::CMD_QUERY, 0, 0, 1, 1025, 1'b1, 0, 0, rmmq_pkg::STATUS_INVALID);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg)
        write_count(directed_steps[i].count_value);
      else
        send_item(directed_steps[i].item, directed_steps[i].pinned, directed_steps[i].result);
    end

    run_phase(11'd1024, 40);
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) run_phase(CW'($urandom_range(1, 16)), $urandom_range(20, 80));
      else if (pick < 90) run_phase(CW'($urandom_range(17, 64)), $urandom_range(20, 80));
      else if (pick < 96) run_phase(CW'($urandom_range(65, 256)), $urandom_range(20, 80));
      else run_phase(CW'($urandom_range(0, 2)), $urandom_range(20, 80));
    end

    wait_drain();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_range_max_min_query_tree: PASS");
    end else begin
      $display("tb_range_max_min_query_tree: FAIL");
    end
    $finish;
  end

endmodule
